// ----- rtl/core/hla_pkg.sv -----
// Package for the HITS link analysis block: sizes, codes, payload and
// controller/datapath interface types. No dependencies.
package hla_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int SCORE_BITS = 16;

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int ADJ_AW    = 2 * NODE_W;
  localparam int FRAC_BITS = SCORE_BITS - 1;
  localparam int SUM_W     = SCORE_BITS + NODE_W;
  localparam int ACC_W     = ((2 * SUM_W + NODE_W + 1) / 2) * 2;
  localparam int ROOT_W    = ACC_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int STEP_W    = $clog2(ROOT_W + 1);

  localparam int NODE_COUNT_W = 11;
  localparam int ITER_W       = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;
  localparam logic [ITER_W-1:0]       ITER_RESET       = 16'd100;

  localparam logic [SCORE_BITS-1:0] SCORE_ONE = SCORE_BITS'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER       = 1'd1;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [9:0] row_node;
    logic [9:0] col_node;
    logic       edge_present;
    logic [9:0] query_node;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] hub_score;
    logic [15:0] authority_score;
    logic        zero_norm_seen;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RDOUT, S_INIT, S_PHASE, S_ROW, S_WALK, S_FIN1, S_FIN2, S_FIN3,
    S_SQRT, S_NCHK, S_NROW, S_NREQ, S_NINIT, S_NDIV, S_NWR, S_PEND, S_DONE
  } state_t;

  typedef struct packed {
    logic              adj_we;
    logic              walk_rd;
    logic              self_node;
    logic [ADJ_AW-1:0] adj_raddr;
    logic [NODE_W-1:0] score_addr;
    logic [NODE_W-1:0] score_waddr;
    logic [NODE_W-1:0] raw_addr;
    logic              phase;     // 0 hub pass, 1 authority pass
    logic              sum_clr;
    logic              sq_load;
    logic              acc_clr;
    logic              acc_add;
    logic              clear_we;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              norm_chk;
    logic              div_init;
    logic              div_step;
    logic              vec_we;
    logic              chg_clr;
    logic              zflag_clr;
    logic              query_rd;
    logic              out_read;
    logic              out_done;
  } cmd_t;

  typedef struct packed {
    logic changed;
  } stat_t;

endpackage

// ----- rtl/core/hla_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/hla_ctrl.sv -----
// Controller for the HITS block: intake, config registers, loop counters
// and the compute sequence. Depends on hla_pkg.
module hla_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  hla_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               cfg_we,
  input  logic [hla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hla_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hla_pkg::cmd_t                      cmd,
  input  hla_pkg::stat_t                     stat
);
  import hla_pkg::*;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        o, o_next, k, k_next;
  logic [STEP_W-1:0]       step, step_next;
  logic [ITER_W-1:0]       round, round_next;
  logic                    phase, phase_next;
  logic [9:0]              qry, qry_next;
  logic                    out_valid_next;
  logic [NODE_COUNT_W-1:0] node_count;
  logic [ITER_W-1:0]       iteration_count;
  logic [CNT_W-1:0]        n_eff;
  logic [ITER_W-1:0]       round_inc;

  assign n_eff = (int'(node_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);
  assign round_inc = round + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      node_count      <= NODE_COUNT_RESET;
      iteration_count <= ITER_RESET;
      o               <= '0;
      k               <= '0;
      step            <= '0;
      round           <= '0;
      phase           <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      o         <= o_next;
      k         <= k_next;
      step      <= step_next;
      round     <= round_next;
      phase     <= phase_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_COUNT: node_count <= NODE_COUNT_W'(cfg_data);
          CFG_ITER:       iteration_count <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    qry <= qry_next;
  end

  always_comb begin
    state_next     = state;
    o_next         = o;
    k_next         = k;
    step_next      = step;
    round_next     = round;
    phase_next     = phase;
    qry_next       = qry;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.phase      = phase;
    cmd.raw_addr   = o[NODE_W-1:0];
    cmd.score_addr = o[NODE_W-1:0];
    cmd.score_waddr = o[NODE_W-1:0];
    cmd.self_node  = (o == k);
    cmd.adj_raddr  = phase ?
        ((ADJ_AW'(k[NODE_W-1:0]) << NODE_W) | ADJ_AW'(o[NODE_W-1:0])) :
        ((ADJ_AW'(o[NODE_W-1:0]) << NODE_W) | ADJ_AW'(k[NODE_W-1:0]));

    case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.score_addr = NODE_W'(in_data.query_node);
        if (in_valid) begin
          case (in_data.action)
            ACT_LOAD: cmd.adj_we = 1'b1;
            ACT_COMPUTE: begin
              cmd.zflag_clr = 1'b1;
              k_next        = '0;
              state_next    = S_INIT;
            end
            ACT_READ: begin
              cmd.query_rd = 1'b1;
              qry_next     = in_data.query_node;
              state_next   = S_RDOUT;
            end
            default: ;
          endcase
        end
      end
      S_RDOUT: begin
        cmd.score_addr = NODE_W'(qry);
        if (!out_valid || out_ready) begin
          cmd.out_read   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_INIT: begin
        cmd.clear_we    = 1'b1;
        cmd.score_waddr = k[NODE_W-1:0];
        k_next          = k + 1'b1;
        if (k == CNT_W'(MAX_NODES - 1)) begin
          round_next = '0;
          phase_next = 1'b0;
          state_next = (iteration_count == '0) ? S_DONE : S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.acc_clr = 1'b1;
        cmd.chg_clr = !phase;
        o_next      = '0;
        state_next  = S_ROW;
      end
      S_ROW: begin
        if (o == n_eff) begin
          cmd.sqrt_init = 1'b1;
          step_next     = '0;
          state_next    = S_SQRT;
        end else begin
          cmd.sum_clr = 1'b1;
          k_next      = '0;
          state_next  = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_rd    = 1'b1;
        cmd.score_addr = k[NODE_W-1:0];
        k_next         = k + 1'b1;
        if (k == CNT_W'(n_eff - 1'b1)) begin
          state_next = S_FIN1;
        end
      end
      S_FIN1: state_next = S_FIN2;  // last product lands in the sum
      S_FIN2: begin
        cmd.sq_load = 1'b1;
        state_next  = S_FIN3;
      end
      S_FIN3: begin
        cmd.acc_add = 1'b1;
        o_next      = o + 1'b1;
        state_next  = S_ROW;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == STEP_W'(ROOT_W - 1)) begin
          state_next = S_NCHK;
        end
      end
      S_NCHK: begin
        cmd.norm_chk = 1'b1;
        o_next       = '0;
        state_next   = S_NROW;
      end
      S_NROW: state_next = (o == n_eff) ? S_PEND : S_NREQ;
      S_NREQ: state_next = S_NINIT;
      S_NINIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_NDIV;
      end
      S_NDIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_NWR;
        end
      end
      S_NWR: begin
        cmd.vec_we = 1'b1;
        o_next     = o + 1'b1;
        state_next = S_NROW;
      end
      S_PEND: begin
        if (!phase) begin
          phase_next = 1'b1;
          state_next = S_PHASE;
        end else begin
          round_next = round_inc;
          phase_next = 1'b0;
          // a round that changes nothing is a fixed point
          if (!stat.changed || round_inc == iteration_count) begin
            state_next = S_DONE;
          end else begin
            state_next = S_PHASE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_done   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/hla_dp.sv -----
// Datapath for the HITS block: adjacency and score memories, row sums,
// square accumulator, square root, divider and result register.
// Depends on hla_pkg and hla_ram.
module hla_dp (
  input  logic               clk,
  input  logic               rst,
  input  hla_pkg::in_item_t  in_data,
  input  hla_pkg::cmd_t      cmd,
  output hla_pkg::stat_t     stat,
  output hla_pkg::out_item_t out_data
);
  import hla_pkg::*;

  logic                  adj_we, adj_rd;
  logic [ADJ_AW-1:0]     adj_waddr;
  logic                  hub_we, auth_we;
  logic [SCORE_BITS-1:0] score_wdata, hub_rd, auth_rd, src_score;
  logic [SUM_W-1:0]      raw_rd;

  logic                  walk_v, self_q;
  logic [SUM_W-1:0]      sum;
  logic [2*SUM_W-1:0]    sq;
  logic [ACC_W-1:0]      acc;

  logic [ACC_W-1:0]      sx;
  logic [REM_W-1:0]      srem;
  logic [ROOT_W-1:0]     root;
  logic [REM_W+1:0]      s_rem2, s_trial;

  logic [ROOT_W-1:0]     drem;
  logic [ROOT_W:0]       d_r2;
  logic [DIV_STEPS-1:0]  dq;
  logic                  dzero, dsat;
  logic [DIV_STEPS:0]    dq_rnd;
  logic [SCORE_BITS-1:0] div_res, old_q;

  logic zflag, changed, scores_valid, q_oor;

  assign adj_we    = cmd.adj_we && (int'(in_data.row_node) < MAX_NODES) &&
                     (int'(in_data.col_node) < MAX_NODES);
  assign adj_waddr = (ADJ_AW'(in_data.row_node) << NODE_W) | ADJ_AW'(in_data.col_node);

  hla_ram #(.WIDTH(1), .DEPTH(1 << ADJ_AW)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(in_data.edge_present),
    .raddr(cmd.adj_raddr), .rdata(adj_rd)
  );

  assign score_wdata = cmd.clear_we ? SCORE_ONE : div_res;
  assign hub_we      = cmd.clear_we || (cmd.vec_we && !cmd.phase);
  assign auth_we     = cmd.clear_we || (cmd.vec_we && cmd.phase);

  hla_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_NODES)) u_hub (
    .clk(clk), .we(hub_we), .waddr(cmd.score_waddr), .wdata(score_wdata),
    .raddr(cmd.score_addr), .rdata(hub_rd)
  );

  hla_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_NODES)) u_auth (
    .clk(clk), .we(auth_we), .waddr(cmd.score_waddr), .wdata(score_wdata),
    .raddr(cmd.score_addr), .rdata(auth_rd)
  );

  hla_ram #(.WIDTH(SUM_W), .DEPTH(MAX_NODES)) u_raw (
    .clk(clk), .we(cmd.sq_load), .waddr(cmd.raw_addr), .wdata(sum),
    .raddr(cmd.raw_addr), .rdata(raw_rd)
  );

  // hub pass sums authorities of out-links, authority pass sums hubs of in-links
  assign src_score = cmd.phase ? hub_rd : auth_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_v       <= 1'b0;
      zflag        <= 1'b0;
      changed      <= 1'b0;
      scores_valid <= 1'b0;
    end else begin
      walk_v <= cmd.walk_rd;
      if (cmd.zflag_clr) begin
        zflag <= 1'b0;
      end else if (cmd.norm_chk && root == '0) begin
        zflag <= 1'b1;
      end
      if (cmd.chg_clr) begin
        changed <= 1'b0;
      end else if (cmd.vec_we && div_res != old_q) begin
        changed <= 1'b1;
      end
      if (cmd.clear_we) begin
        scores_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    self_q <= cmd.self_node;
    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (walk_v && !self_q && adj_rd) begin
      sum <= sum + SUM_W'(src_score);
    end
    if (cmd.sq_load) begin
      sq <= sum * sum;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(sq);
    end
  end

  // square root, two radicand bits per step
  assign s_rem2  = {srem, sx[ACC_W-1 -: 2]};
  assign s_trial = (REM_W + 2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sx   <= acc;
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      sx <= sx << 2;
      if (s_rem2 >= s_trial) begin
        srem <= REM_W'(s_rem2 - s_trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        srem <= REM_W'(s_rem2);
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // restoring divide raw/norm, one quotient bit per step
  assign d_r2    = {drem, 1'b0};
  assign dq_rnd  = ((DIV_STEPS + 1)'(dq) + 1'b1) >> 1;
  assign div_res = dzero ? '0 :
                   (dsat || dq_rnd > (DIV_STEPS + 1)'(SCORE_ONE)) ? SCORE_ONE :
                   SCORE_BITS'(dq_rnd);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem  <= ROOT_W'(raw_rd);
      dq    <= '0;
      dzero <= (root == '0);
      dsat  <= (ROOT_W'(raw_rd) >= root);
      old_q <= cmd.phase ? auth_rd : hub_rd;
    end else if (cmd.div_step) begin
      if (d_r2 >= (ROOT_W + 1)'(root)) begin
        drem <= ROOT_W'(d_r2 - (ROOT_W + 1)'(root));
        dq   <= {dq[DIV_STEPS-2:0], 1'b1};
      end else begin
        drem <= ROOT_W'(d_r2);
        dq   <= {dq[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_rd) begin
      q_oor <= (int'(in_data.query_node) >= MAX_NODES);
    end
    if (cmd.out_read) begin
      out_data.result_kind     <= KIND_READ;
      out_data.hub_score       <= q_oor ? '0 : scores_valid ? 16'(hub_rd) : 16'(SCORE_ONE);
      out_data.authority_score <= q_oor ? '0 : scores_valid ? 16'(auth_rd) : 16'(SCORE_ONE);
      out_data.zero_norm_seen  <= zflag;
    end else if (cmd.out_done) begin
      out_data.result_kind     <= KIND_DONE;
      out_data.hub_score       <= '0;
      out_data.authority_score <= '0;
      out_data.zero_norm_seen  <= zflag;
    end
  end

  assign stat.changed = changed;

endmodule

// ----- rtl/core/hits_link_analysis.sv -----
// HITS hubs and authorities by power iteration on a loaded adjacency matrix.
// Top level: controller and datapath. Depends on hla_pkg, hla_ctrl, hla_dp.
//
// An edge load is written while the block stays idle, so it takes the next item
// at once. A read passes through a readout state and registers its result once
// the output register is free. A compute first sets every score of all MAX_NODES
// nodes to 1.0, then each round makes a hub pass and an authority pass over n nodes:
// the matrix walks read one adjacency bit per cycle from the bit memory and
// dominate, then a two-bit-per-step square root and a one-bit-per-step divide
// per node normalize the vector. Rounds stop early once a round changes no
// score. No item is taken while a compute runs; config may be written while idle.
module hits_link_analysis (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hla_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hla_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [hla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hla_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hla_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  hla_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat)
  );

  hla_dp u_dp (
    .clk(clk), .rst(rst), .in_data(in_data),
    .cmd(cmd), .stat(stat), .out_data(out_data)
  );

  a_compute_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.action == ACT_COMPUTE |=> !in_ready)
    else $error("intake not stalled after compute transfer");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == KIND_DONE |->
      out_data.hub_score == '0 && out_data.authority_score == '0)
    else $error("compute result carries nonzero scores");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ----- bench/tb_hits_link_analysis.sv -----
// Self-checking bench for hits_link_analysis: drives edge loads, computes and
// reads through valid/ready, predicts every result and compares. Needs hla_pkg.
module tb_hits_link_analysis;
  timeunit 1ns;
  timeprecision 1ps;
  import hla_pkg::*;

  localparam int STALL_LIMIT = 200000;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hits_link_analysis dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  bit adj_bits[MAX_NODES*MAX_NODES];
  bit edge_planned[MAX_NODES*MAX_NODES];
  longint unsigned hub_q[MAX_NODES], auth_q[MAX_NODES], raw_q[MAX_NODES];
  longint unsigned prev_hub[MAX_NODES], prev_auth[MAX_NODES];
  longint unsigned norm_acc;
  bit zflag;
  int unsigned node_cfg = NODE_COUNT_RESET;
  int unsigned iter_cfg = ITER_RESET;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int mismatches = 0;
  bit no_idle = 1'b0;
  bit timed_out = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned q_div(longint unsigned raw, longint unsigned norm);
    longint unsigned rem, q;
    rem = raw;
    q = 0;
    if (raw >= norm) return ONE;
    for (int k = 0; k <= FRAC_BITS; k++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= norm) begin
        rem -= norm;
        q |= 1;
      end
    end
    q = (q + 1) >> 1;
    return (q > ONE) ? ONE : q;
  endfunction

  // fold raw sums into the hub (0) or authority (1) vector
  function automatic void normalize_vec(bit to_auth, int n);
    longint unsigned norm;
    norm = int_sqrt(norm_acc);
    for (int i = 0; i < n; i++) begin
      if (to_auth) auth_q[i] = (norm == 0) ? 0 : q_div(raw_q[i], norm);
      else hub_q[i] = (norm == 0) ? 0 : q_div(raw_q[i], norm);
    end
    if (norm == 0) zflag = 1'b1;
  endfunction

  function automatic void run_hits();
    int n;
    longint unsigned s;
    bit same;
    n = (node_cfg > MAX_NODES) ? MAX_NODES : node_cfg;
    for (int i = 0; i < MAX_NODES; i++) begin
      hub_q[i] = ONE;
      auth_q[i] = ONE;
    end
    zflag = 1'b0;
    for (int r = 0; r < iter_cfg; r++) begin
      prev_hub = hub_q;
      prev_auth = auth_q;
      norm_acc = 0;
      for (int i = 0; i < n; i++) begin
        s = 0;
        for (int j = 0; j < n; j++)
          if (i != j && adj_bits[i*MAX_NODES+j]) s += auth_q[j];
        raw_q[i] = s;
        norm_acc += s * s;  // cannot saturate at these sizes
      end
      normalize_vec(1'b0, n);
      norm_acc = 0;
      for (int j = 0; j < n; j++) begin
        s = 0;
        for (int i = 0; i < n; i++)
          if (i != j && adj_bits[i*MAX_NODES+j]) s += hub_q[i];
        raw_q[j] = s;
        norm_acc += s * s;
      end
      normalize_vec(1'b1, n);
      same = 1'b1;
      for (int i = 0; i < n; i++)
        if (hub_q[i] != prev_hub[i] || auth_q[i] != prev_auth[i]) same = 1'b0;
      if (same) break;
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    out_item_t o;
    o = '0;
    case (it.action)
      ACT_LOAD: adj_bits[it.row_node*MAX_NODES+it.col_node] = it.edge_present;
      ACT_COMPUTE: begin
        run_hits();
        o.result_kind = KIND_DONE;
        o.zero_norm_seen = zflag;
        expected_results.push_back(o);
      end
      ACT_READ: begin
        o.result_kind = KIND_READ;
        o.hub_score = hub_q[it.query_node][15:0];
        o.authority_score = auth_q[it.query_node][15:0];
        o.zero_norm_seen = zflag;
        expected_results.push_back(o);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 60) return 0;
    if (p < 90) return $urandom_range(3, 1);
    if (p < 98) return $urandom_range(15, 4);
    return $urandom_range(60, 20);
  endfunction

  // driver
  int in_gap = 0;
  in_item_t cur_item;
  always @(posedge clk) begin
    logic nv;
    nv = in_valid;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_item(cur_item);
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_data <= cur_item;
          nv = 1'b1;
          in_gap = pick_gap();
        end
      end
    end
    in_valid <= nv;
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_results.pop_front();
        if (out_data.result_kind !== e.result_kind || out_data.hub_score !== e.hub_score ||
            out_data.authority_score !== e.authority_score ||
            out_data.zero_norm_seen !== e.zero_norm_seen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  // watchdog on cycles with no transfer on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_load(int r, int c, bit b);
    in_item_t it;
    it = '0;
    it.action = ACT_LOAD;
    it.row_node = r[9:0];
    it.col_node = c[9:0];
    it.edge_present = b;
    it.query_node = 10'($urandom_range(1023));
    edge_planned[r*MAX_NODES+c] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic push_op(logic [1:0] act, int q);
    in_item_t it;
    it = '0;
    it.action = act;
    it.row_node = 10'($urandom_range(1023));
    it.col_node = 10'($urandom_range(1023));
    it.edge_present = 1'($urandom_range(1));
    it.query_node = q[9:0];
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    if (idx == CFG_NODE_COUNT) node_cfg = val & 32'h7FF;
    else iter_cfg = val & 32'hFFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // every edge a compute can read must be loaded first
  task automatic fill_square(int n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!edge_planned[r*MAX_NODES+c]) push_load(r, c, 1'($urandom_range(1)));
  endtask

  initial begin
    int n, p, budget;
    for (int i = 0; i < MAX_NODES; i++) begin
      hub_q[i] = ONE;
      auth_q[i] = ONE;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset scores, corners, ignored action
    push_op(ACT_READ, 0);
    push_op(ACT_READ, 1023);
    push_load(1023, 1023, 1'b1);
    push_load(0, 1023, 1'b0);
    push_op(2'd3, 5);
    // converging two-node graph under the largest round count
    write_cfg(CFG_NODE_COUNT, 2);
    write_cfg(CFG_ITER, 65535);
    push_load(0, 0, 1'b1);
    push_load(0, 1, 1'b1);
    push_load(1, 0, 1'b0);
    push_load(1, 1, 1'b0);
    push_op(ACT_COMPUTE, 0);
    push_op(ACT_READ, 0);
    push_op(ACT_READ, 1);
    // one node: zero norm
    write_cfg(CFG_NODE_COUNT, 1);
    write_cfg(CFG_ITER, 5);
    push_op(ACT_COMPUTE, 0);
    push_op(ACT_READ, 0);
    // zero nodes, then zero rounds
    write_cfg(CFG_NODE_COUNT, 0);
    push_op(ACT_COMPUTE, 0);
    push_op(ACT_READ, 1);
    write_cfg(CFG_NODE_COUNT, 2);
    write_cfg(CFG_ITER, 0);
    push_op(ACT_COMPUTE, 0);
    push_op(ACT_READ, 0);
    // counts at and above the array size: reads only
    write_cfg(CFG_NODE_COUNT, 2047);
    push_op(ACT_READ, 1);
    write_cfg(CFG_NODE_COUNT, 1024);
    push_op(ACT_READ, 0);

    budget = 700;
    while (budget > 0) begin
      p = $urandom_range(99);
      n = (p < 70) ? $urandom_range(5, 2) : $urandom_range(8, 6);
      no_idle = ($urandom_range(3) == 0);
      write_cfg(CFG_NODE_COUNT, n);
      write_cfg(CFG_ITER, ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2));
      fill_square(n);
      for (int k = 0; k < 45; k++) begin
        p = $urandom_range(99);
        if (p < 55) push_load($urandom_range(n - 1), $urandom_range(n - 1),
                              1'($urandom_range(1)));
        else if (p < 65) push_load($urandom_range(1023), $urandom_range(1023),
                                   1'($urandom_range(1)));
        else if (p < 75) push_op(ACT_COMPUTE, $urandom_range(1023));
        else if (p < 88) push_op(ACT_READ, $urandom_range(n - 1));
        else if (p < 95) push_op(ACT_READ, $urandom_range(1023));
        else begin
          push_op(2'd3, $urandom_range(1023));
          k--;
          budget--;
        end
      end
      push_op(ACT_COMPUTE, 0);
      push_op(ACT_READ, $urandom_range(n - 1));
      budget -= 47;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
